@@ rtl/core/ptsel_pkg.sv @@
// Shared constants and codes for the pt track selector.
package ptsel_pkg;

    localparam int MAX_TRACKS_DEF     = 256;
    localparam int TOP_PER_CHARGE_DEF = 2;
    localparam int TOP_ANY_DEF        = 4;

    localparam int PT_W   = 16;
    localparam int CHG_W  = 2;
    localparam int IDX_W  = 8;
    localparam int PCNT_W = 2;
    localparam int ACNT_W = 3;

    localparam int CHG_REP = 2;
    localparam int ANY_REP = 4;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 72;

    localparam logic [CHG_W-1:0] CHG_POS = 2'b01;
    localparam logic [CHG_W-1:0] CHG_NEG = 2'b11;

endpackage

@@ rtl/core/top_pt_track_selector.sv @@
// Top level: streaming top-k track selector by pt and charge.
//
//  channel  | dir | fields
//  ---------+-----+--------------------------------------------------------------
//  s_axis   | in  | tdata: pt, charge; tlast: last (final track of the event)
//  m_axis   | out | tdata: 8 indices, pos/neg/any counts, one word per event
//
//  One word per cycle sustained while no last word waits on a stalled m_axis;
//  a word passes an input register, then the parallel compare/insert stage
//  that updates the ranked lists and, on a last word, loads the result register.
//  Reset (i_rst_n low, synchronous) empties all lists and the track counter.
//  A stalled m_axis only holds off input when a last word waits to report.
module top_pt_track_selector #(
    parameter int MAX_TRACKS     = ptsel_pkg::MAX_TRACKS_DEF,
    parameter int TOP_PER_CHARGE = ptsel_pkg::TOP_PER_CHARGE_DEF,
    parameter int TOP_ANY        = ptsel_pkg::TOP_ANY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] pt, [17:16] charge, [23:18] zero
    input  logic [ptsel_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] pos_first, [15:8] pos_second, [23:16] neg_first, [31:24] neg_second,
    // [39:32] any_first, [47:40] any_second, [55:48] any_third,
    // [63:56] any_fourth, [65:64] pos_count, [67:66] neg_count,
    // [70:68] any_count, [71] zero
    output logic [ptsel_pkg::M_DATA_W-1:0] m_axis_tdata
);

    import ptsel_pkg::*;

    localparam int NUM_W   = $clog2(MAX_TRACKS + 1);
    localparam int POS_REP = (TOP_PER_CHARGE < CHG_REP) ? TOP_PER_CHARGE : CHG_REP;
    localparam int ANY_R   = (TOP_ANY < ANY_REP) ? TOP_ANY : ANY_REP;

    // input register
    logic              r_in_vld;
    logic [PT_W-1:0]   r_pt;
    logic [CHG_W-1:0]  r_chg;
    logic              r_last;

    logic [NUM_W-1:0]  r_num;

    logic [IDX_W-1:0]  r_pos_idx [TOP_PER_CHARGE];
    logic [PT_W-1:0]   r_pos_pt  [TOP_PER_CHARGE];
    logic [IDX_W-1:0]  r_neg_idx [TOP_PER_CHARGE];
    logic [PT_W-1:0]   r_neg_pt  [TOP_PER_CHARGE];
    logic [IDX_W-1:0]  r_any_idx [TOP_ANY];
    logic [PT_W-1:0]   r_any_pt  [TOP_ANY];

    logic [IDX_W-1:0]  n_pos_idx [TOP_PER_CHARGE];
    logic [PT_W-1:0]   n_pos_pt  [TOP_PER_CHARGE];
    logic [IDX_W-1:0]  n_neg_idx [TOP_PER_CHARGE];
    logic [PT_W-1:0]   n_neg_pt  [TOP_PER_CHARGE];
    logic [IDX_W-1:0]  n_any_idx [TOP_ANY];
    logic [PT_W-1:0]   n_any_pt  [TOP_ANY];

    logic                    r_out_vld;
    logic [M_DATA_W-1:0]     r_out_data;
    logic [M_DATA_W-1:0]     n_out_data;

    logic                    out_free;
    logic                    adv;
    logic                    in_range;
    logic                    take_pos;
    logic                    take_neg;
    logic                    take_any;
    logic [IDX_W-1:0]        cur_idx;
    logic [TOP_PER_CHARGE-1:0] pos_gt;
    logic [TOP_PER_CHARGE-1:0] neg_gt;
    logic [TOP_ANY-1:0]        any_gt;

    logic [IDX_W-1:0]  rep_pos [CHG_REP];
    logic [IDX_W-1:0]  rep_neg [CHG_REP];
    logic [IDX_W-1:0]  rep_any [ANY_REP];
    logic [PCNT_W-1:0] pos_cnt;
    logic [PCNT_W-1:0] neg_cnt;
    logic [ACNT_W-1:0] any_cnt;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign adv           = r_in_vld && (!r_last || out_free);
    assign s_axis_tready = !r_in_vld || adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign in_range = (r_num < NUM_W'(MAX_TRACKS));
    assign cur_idx  = IDX_W'(r_num);
    assign take_any = adv && in_range;
    assign take_pos = take_any && (r_chg == CHG_POS);
    assign take_neg = take_any && (r_chg == CHG_NEG);

    always_comb begin
        for (int k = 0; k < TOP_PER_CHARGE; k++) begin
            pos_gt[k] = r_pt > r_pos_pt[k];
            neg_gt[k] = r_pt > r_neg_pt[k];
        end
        for (int k = 0; k < TOP_ANY; k++) begin
            any_gt[k] = r_pt > r_any_pt[k];
        end
    end

    // lists stay sorted descending, so the compare vector is monotone
    always_comb begin
        n_pos_idx = r_pos_idx;
        n_pos_pt  = r_pos_pt;
        if (take_pos && pos_gt[0]) begin
            n_pos_idx[0] = cur_idx;
            n_pos_pt[0]  = r_pt;
        end
        for (int k = 1; k < TOP_PER_CHARGE; k++) begin
            if (take_pos && pos_gt[k]) begin
                if (pos_gt[k-1]) begin
                    n_pos_idx[k] = r_pos_idx[k-1];
                    n_pos_pt[k]  = r_pos_pt[k-1];
                end else begin
                    n_pos_idx[k] = cur_idx;
                    n_pos_pt[k]  = r_pt;
                end
            end
        end
    end

    always_comb begin
        n_neg_idx = r_neg_idx;
        n_neg_pt  = r_neg_pt;
        if (take_neg && neg_gt[0]) begin
            n_neg_idx[0] = cur_idx;
            n_neg_pt[0]  = r_pt;
        end
        for (int k = 1; k < TOP_PER_CHARGE; k++) begin
            if (take_neg && neg_gt[k]) begin
                if (neg_gt[k-1]) begin
                    n_neg_idx[k] = r_neg_idx[k-1];
                    n_neg_pt[k]  = r_neg_pt[k-1];
                end else begin
                    n_neg_idx[k] = cur_idx;
                    n_neg_pt[k]  = r_pt;
                end
            end
        end
    end

    always_comb begin
        n_any_idx = r_any_idx;
        n_any_pt  = r_any_pt;
        if (take_any && any_gt[0]) begin
            n_any_idx[0] = cur_idx;
            n_any_pt[0]  = r_pt;
        end
        for (int k = 1; k < TOP_ANY; k++) begin
            if (take_any && any_gt[k]) begin
                if (any_gt[k-1]) begin
                    n_any_idx[k] = r_any_idx[k-1];
                    n_any_pt[k]  = r_any_pt[k-1];
                end else begin
                    n_any_idx[k] = cur_idx;
                    n_any_pt[k]  = r_pt;
                end
            end
        end
    end

    // report: empty slot reads 0 and is not counted
    always_comb begin
        pos_cnt = '0;
        neg_cnt = '0;
        any_cnt = '0;
        for (int k = 0; k < CHG_REP; k++) begin
            rep_pos[k] = '0;
            rep_neg[k] = '0;
        end
        for (int k = 0; k < ANY_REP; k++) begin
            rep_any[k] = '0;
        end
        for (int k = 0; k < POS_REP; k++) begin
            if (n_pos_pt[k] != '0) begin
                rep_pos[k] = n_pos_idx[k];
                pos_cnt    = pos_cnt + PCNT_W'(1);
            end
            if (n_neg_pt[k] != '0) begin
                rep_neg[k] = n_neg_idx[k];
                neg_cnt    = neg_cnt + PCNT_W'(1);
            end
        end
        for (int k = 0; k < ANY_R; k++) begin
            if (n_any_pt[k] != '0) begin
                rep_any[k] = n_any_idx[k];
                any_cnt    = any_cnt + ACNT_W'(1);
            end
        end
        n_out_data = {1'b0, any_cnt, neg_cnt, pos_cnt,
                      rep_any[3], rep_any[2], rep_any[1], rep_any[0],
                      rep_neg[1], rep_neg[0], rep_pos[1], rep_pos[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_pt   <= s_axis_tdata[PT_W-1:0];
            r_chg  <= s_axis_tdata[PT_W+CHG_W-1:PT_W];
            r_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_last)) begin
            r_num <= '0;
            for (int k = 0; k < TOP_PER_CHARGE; k++) begin
                r_pos_idx[k] <= '0;
                r_pos_pt[k]  <= '0;
                r_neg_idx[k] <= '0;
                r_neg_pt[k]  <= '0;
            end
            for (int k = 0; k < TOP_ANY; k++) begin
                r_any_idx[k] <= '0;
                r_any_pt[k]  <= '0;
            end
        end else begin
            if (take_any) begin
                r_num <= r_num + NUM_W'(1);
            end
            r_pos_idx <= n_pos_idx;
            r_pos_pt  <= n_pos_pt;
            r_neg_idx <= n_neg_idx;
            r_neg_pt  <= n_neg_pt;
            r_any_idx <= n_any_idx;
            r_any_pt  <= n_any_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (adv && r_last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ rtl/core/ptsel_chk.sv @@
// Port-level checker for the pt track selector, bound to the top level.
module ptsel_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ptsel_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ptsel_pkg::M_DATA_W-1:0] m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // no pending result means input is never blocked
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // counts in range, pad bit zero
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[71] && (m_axis_tdata[65:64] != 2'd3)
            && (m_axis_tdata[67:66] != 2'd3) && (m_axis_tdata[70:68] <= 3'd4))
        else $error("fill count out of range");

    // empty per-charge slots and an empty fourth any slot read zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[65:64] != 2'd0) || (m_axis_tdata[7:0] == 8'd0))
            && ((m_axis_tdata[65:64] == 2'd2) || (m_axis_tdata[15:8] == 8'd0))
            && ((m_axis_tdata[67:66] != 2'd0) || (m_axis_tdata[23:16] == 8'd0))
            && ((m_axis_tdata[67:66] == 2'd2) || (m_axis_tdata[31:24] == 8'd0))
            && ((m_axis_tdata[70:68] == 3'd4) || (m_axis_tdata[63:56] == 8'd0)))
        else $error("empty slot reports nonzero index");

endmodule

bind top_pt_track_selector ptsel_chk u_ptsel_chk (.*);

@@ sim/ptsel_event_checker.sv @@
// Checker for the pt track selector: ranks tracks per event and compares each result word.
module ptsel_event_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // [15:0] pt, [17:16] charge, [23:18] zero
    input  logic [ptsel_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] pos_first ... [63:56] any_fourth, [65:64] pos_count, [67:66] neg_count,
    // [70:68] any_count, [71] zero
    input  logic [ptsel_pkg::M_DATA_W-1:0] m_axis_tdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptsel_pkg::*;

    localparam int RANK_MAX = (TOP_ANY_DEF > TOP_PER_CHARGE_DEF) ? TOP_ANY_DEF
                                                                 : TOP_PER_CHARGE_DEF;

    typedef enum int {
        RL_POS = 0,
        RL_NEG = 1,
        RL_ANY = 2
    } t_rank_list;

    typedef struct packed {
        logic              pad;
        logic [ACNT_W-1:0] any_count;
        logic [PCNT_W-1:0] neg_count;
        logic [PCNT_W-1:0] pos_count;
        logic [IDX_W-1:0]  any_fourth;
        logic [IDX_W-1:0]  any_third;
        logic [IDX_W-1:0]  any_second;
        logic [IDX_W-1:0]  any_first;
        logic [IDX_W-1:0]  neg_second;
        logic [IDX_W-1:0]  neg_first;
        logic [IDX_W-1:0]  pos_second;
        logic [IDX_W-1:0]  pos_first;
    } t_event_summary;

    int              track_total;
    int              best_num [3][RANK_MAX];
    logic [PT_W-1:0] best_pt  [3][RANK_MAX];
    t_event_summary  summaries_due [$];
    int              mismatches = 0;
    int              due_count  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = due_count;

    function automatic void clear_lists();
        track_total = 0;
        for (int l = 0; l < 3; l++) begin
            for (int k = 0; k < RANK_MAX; k++) begin
                best_num[l][k] = 0;
                best_pt[l][k]  = '0;
            end
        end
    endfunction

    // strict compare: an equal pt never displaces an earlier track
    function automatic void rank_in(t_rank_list list, int num, logic [PT_W-1:0] pt);
        int depth = (list == RL_ANY) ? TOP_ANY_DEF : TOP_PER_CHARGE_DEF;
        int p = 0;
        if (pt == '0)
            return;
        while (p < depth && !(pt > best_pt[list][p]))
            p++;
        if (p >= depth)
            return;
        for (int k = depth - 1; k > p; k--) begin
            best_num[list][k] = best_num[list][k-1];
            best_pt[list][k]  = best_pt[list][k-1];
        end
        best_num[list][p] = num;
        best_pt[list][p]  = pt;
    endfunction

    function automatic void take_track(logic [PT_W-1:0] pt, logic [CHG_W-1:0] chg,
                                       logic last);
        t_event_summary   sum;
        logic [IDX_W-1:0] shown [3][ANY_REP];
        int               cnt   [3];
        if (track_total < MAX_TRACKS_DEF) begin
            if (chg == CHG_POS)
                rank_in(RL_POS, track_total, pt);
            else if (chg == CHG_NEG)
                rank_in(RL_NEG, track_total, pt);
            rank_in(RL_ANY, track_total, pt);
            track_total++;
        end
        if (!last)
            return;
        for (int l = 0; l < 3; l++) begin
            int depth;
            int fields;
            depth  = (l == RL_ANY) ? TOP_ANY_DEF : TOP_PER_CHARGE_DEF;
            fields = (l == RL_ANY) ? ANY_REP : CHG_REP;
            cnt[l] = 0;
            for (int k = 0; k < ANY_REP; k++) begin
                shown[l][k] = '0;
                if (k < fields && k < depth && best_pt[l][k] != '0) begin
                    shown[l][k] = best_num[l][k][IDX_W-1:0];
                    cnt[l]++;
                end
            end
        end
        sum            = '0;
        sum.pos_first  = shown[RL_POS][0];
        sum.pos_second = shown[RL_POS][1];
        sum.neg_first  = shown[RL_NEG][0];
        sum.neg_second = shown[RL_NEG][1];
        sum.any_first  = shown[RL_ANY][0];
        sum.any_second = shown[RL_ANY][1];
        sum.any_third  = shown[RL_ANY][2];
        sum.any_fourth = shown[RL_ANY][3];
        sum.pos_count  = cnt[RL_POS][PCNT_W-1:0];
        sum.neg_count  = cnt[RL_NEG][PCNT_W-1:0];
        sum.any_count  = cnt[RL_ANY][ACNT_W-1:0];
        summaries_due.push_back(sum);
        clear_lists();
    endfunction

    function automatic void compare_field(string name, logic [IDX_W-1:0] want,
                                          logic [IDX_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_word(logic [M_DATA_W-1:0] word);
        t_event_summary got;
        t_event_summary want;
        got = word;
        if (summaries_due.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, word);
            mismatches++;
            return;
        end
        want = summaries_due.pop_front();
        compare_field("pos_first",  want.pos_first,  got.pos_first);
        compare_field("pos_second", want.pos_second, got.pos_second);
        compare_field("neg_first",  want.neg_first,  got.neg_first);
        compare_field("neg_second", want.neg_second, got.neg_second);
        compare_field("any_first",  want.any_first,  got.any_first);
        compare_field("any_second", want.any_second, got.any_second);
        compare_field("any_third",  want.any_third,  got.any_third);
        compare_field("any_fourth", want.any_fourth, got.any_fourth);
        compare_field("pos_count",  IDX_W'(want.pos_count), IDX_W'(got.pos_count));
        compare_field("neg_count",  IDX_W'(want.neg_count), IDX_W'(got.neg_count));
        compare_field("any_count",  IDX_W'(want.any_count), IDX_W'(got.any_count));
        compare_field("pad bit",    IDX_W'(want.pad),       IDX_W'(got.pad));
    endfunction

    // result side first: nothing accepted on this edge can report on it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lists();
            summaries_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                take_track(s_axis_tdata[PT_W-1:0], s_axis_tdata[PT_W+CHG_W-1:PT_W],
                           s_axis_tlast);
        end
        due_count = summaries_due.size();
    end

endmodule

@@ sim/top_pt_track_selector_test.sv @@
// Testbench top for the pt track selector: drives track events and gives the verdict.
module top_pt_track_selector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptsel_pkg::*;

    localparam logic [CHG_W-1:0] CHG_NONE = 2'b00;
    localparam logic [CHG_W-1:0] CHG_ODD  = 2'b10;
    localparam int ITEM_TARGET = 1800;
    localparam int QUIET_FROM  = 1550;
    localparam int CYCLE_LIMIT = 600000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;   // [15:0] pt, [17:16] charge, [23:18] zero
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // indices [63:0], counts [70:64], [71] zero

    int fail_count;
    int pending;
    int items_sent  = 0;
    int cycle_count = 0;
    int rx_hold     = 0;
    bit idling      = 1'b1;

    top_pt_track_selector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ptsel_event_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side backpressure in bursts
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else if (i_rst_n && idling && $urandom_range(0, 7) == 0) begin
            rx_hold       <= $urandom_range(1, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_track(input logic [PT_W-1:0] pt, input logic [CHG_W-1:0] chg,
                              input logic last);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-PT_W-CHG_W){1'b0}}, chg, pt};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // half zeros, extremes and small tying values so that ranking order matters
    function automatic logic [PT_W-1:0] pick_pt();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return PT_W'($urandom_range(1, 6));
            default: return PT_W'($urandom);
        endcase
    endfunction

    function automatic logic [CHG_W-1:0] pick_charge();
        case ($urandom_range(0, 7))
            0:          return CHG_NONE;
            1:          return CHG_ODD;
            2, 3, 4:    return CHG_POS;
            default:    return CHG_NEG;
        endcase
    endfunction

    task automatic send_event(input int len);
        for (int n = 0; n < len; n++)
            send_track(pick_pt(), pick_charge(), n == len - 1);
    endtask

    initial begin
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone zero-pt track: every slot empty
        send_track('0, CHG_NONE, 1'b1);
        // extremes, ties, both neutral codes, a zero-pt charged track
        send_track(16'hFFFF, CHG_POS,  1'b0);
        send_track(16'h0001, CHG_NEG,  1'b0);
        send_track(16'h0800, CHG_POS,  1'b0);
        send_track(16'h0800, CHG_POS,  1'b0);
        send_track(16'h0800, CHG_NEG,  1'b0);
        send_track(16'h1234, CHG_ODD,  1'b0);
        send_track(16'hFFFF, CHG_NONE, 1'b0);
        send_track(16'h0000, CHG_POS,  1'b0);
        send_track(16'h8000, CHG_NEG,  1'b0);
        send_track(16'h5555, CHG_POS,  1'b1);
        // track 0 in a slot, told apart from empty by the count
        send_track(16'h00AA, CHG_POS,  1'b1);
        send_track(16'h0000, CHG_NEG,  1'b0);
        send_track(16'h0000, CHG_POS,  1'b1);
        // all equal pt: earliest tracks keep the slots
        send_track(16'h0010, CHG_POS,  1'b0);
        send_track(16'h0010, CHG_NEG,  1'b0);
        send_track(16'h0010, CHG_NONE, 1'b0);
        send_track(16'h0010, CHG_POS,  1'b0);
        send_track(16'h0010, CHG_NEG,  1'b0);
        send_track(16'h0010, CHG_ODD,  1'b1);
        drain();

        // events at and past the track depth
        send_event(MAX_TRACKS_DEF);
        send_event(MAX_TRACKS_DEF + 1);
        send_event($urandom_range(MAX_TRACKS_DEF + 2, MAX_TRACKS_DEF + 44));

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0)
                idling = !idling;
            if (items_sent >= QUIET_FROM)
                idling = 1'b0;
            if ($urandom_range(0, 49) == 0)
                drain();
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
            send_event(len);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ptsel_pkg.sv
rtl/core/top_pt_track_selector.sv
rtl/core/ptsel_chk.sv
sim/ptsel_event_checker.sv
sim/top_pt_track_selector_test.sv
